// ===== hw/rtl/uvs_pkg.sv =====
// Shared types and constants of the UV-sphere vertex and index generator.
`timescale 1ns / 1ps
`default_nettype none
package uvs_pkg;

    localparam int CNT_W        = 9;
    localparam int IDX_W        = 17;
    localparam int PH_W         = 20;
    localparam int DIV_Q_W      = 22;
    localparam int SIN_LAT      = 8;
    localparam int QUEUE_DEPTH  = 4;
    localparam int CFG_IDX_W    = 8;
    localparam int S_TDATA_W    = 24;
    localparam int M_TDATA_W    = 176;

    localparam int MAX_SLICES_DEF = 256;
    localparam int MAX_STACKS_DEF = 256;

    localparam logic [CNT_W-1:0] SLICE_RESET = 9'd16;
    localparam logic [CNT_W-1:0] STACK_RESET = 9'd16;

    localparam logic [CFG_IDX_W-1:0] REG_SLICE_COUNT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STACK_COUNT = 8'd1;

    localparam logic [PH_W-1:0] QUARTER = 20'h40000;

    // Q30 odd polynomial for sine over one quarter turn
    localparam logic [30:0] SIN_A9 = 31'd172271;
    localparam logic [30:0] SIN_COEF [4] = '{31'd5026996, 31'd85569306,
                                             31'd693598669, 31'd1686629713};

    typedef struct packed {
        logic             quad;
        logic [CNT_W-1:0] ring;
        logic [CNT_W-1:0] col;
        logic [IDX_W-1:0] idx0;
        logic [IDX_W-1:0] idx2;
    } item_t;

    typedef struct packed {
        logic               quad;
        logic [IDX_W-1:0]   idx0;
        logic [IDX_W-1:0]   idx2;
        logic signed [14:0] pos_x;
        logic signed [14:0] pos_y;
        logic signed [14:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic [14:0]        tex_u;
        logic [14:0]        tex_v;
        logic signed [15:0] tan_x;
        logic signed [15:0] tan_z;
    } vtx_t;

    // result word as it stands on m_tdata, top field first
    typedef struct packed {
        logic [3:0]         pad;
        logic [IDX_W-1:0]   vertex_index;
        logic signed [15:0] tan_z;
        logic signed [15:0] tan_x;
        logic [14:0]        tex_v;
        logic [14:0]        tex_u;
        logic signed [15:0] norm_z;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_x;
        logic signed [14:0] pos_z;
        logic signed [14:0] pos_y;
        logic signed [14:0] pos_x;
    } out_word_t;

endpackage
`default_nettype wire

// ===== hw/rtl/uv_sphere_vertex_index_gen.sv =====
// Top level of the UV-sphere vertex and triangle index generator.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata: ring, column; s_tuser: mode
//  m_      | out | m_tvalid/m_tready  | m_tdata: vertex fields, index; m_tlast
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data (slice, stack count)
//
// One item enters per cycle while the queue has room; the arithmetic pipe has 33 register stages: the 22-step
// angle divider, the phase stage, the 8-stage sine units, the product and output stages.
// An item passes the queue, the pipe stages and the sequencer register before its result can be taken.
// A vertex item gives one result, a quad item six index results.
// Reset is synchronous, active low; no clearing pass.
// A stall on m_tready or a quad sequence in progress freezes the pipe; the 4-entry queue absorbs the front.
`timescale 1ns / 1ps
`default_nettype none
module uv_sphere_vertex_index_gen #(
    parameter int MAX_SLICES = uvs_pkg::MAX_SLICES_DEF,
    parameter int MAX_STACKS = uvs_pkg::MAX_STACKS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [uvs_pkg::S_TDATA_W-1:0]  s_tdata,   // ring[8:0], column[17:9], zeros
    input  logic                           s_tuser,   // mode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [uvs_pkg::M_TDATA_W-1:0]  m_tdata,   // pos_x, pos_y, pos_z, norm_x,
                                                      // norm_y, norm_z, tex_u, tex_v,
                                                      // tan_x, tan_z, vertex_index, zeros
    output logic                           m_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [uvs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [uvs_pkg::CNT_W-1:0]      cfg_data
);
    logic q_full, q_push, p_in_valid, p_in_ready, p_out_valid, e_in_ready;
    uvs_pkg::item_t q_item, p_item;
    uvs_pkg::vtx_t  p_res;
    logic [uvs_pkg::CNT_W-1:0] sl, st;

    uvs_front #(.MAX_SLICES(MAX_SLICES), .MAX_STACKS(MAX_STACKS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_tvalid), .s_ready(s_tready), .s_quad(s_tuser),
        .s_ring(s_tdata[8:0]), .s_col(s_tdata[17:9]),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .q_full(q_full), .q_push(q_push), .q_item(q_item), .sl(sl), .st(st)
    );

    uvs_fifo u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(q_push), .full(q_full), .wr_item(q_item),
        .rd_valid(p_in_valid), .rd_ready(p_in_ready), .rd_item(p_item)
    );

    uvs_pipe u_pipe (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(p_in_valid), .in_ready(p_in_ready), .in_item(p_item),
        .sl(sl), .st(st),
        .out_valid(p_out_valid), .out_ready(e_in_ready), .out_res(p_res)
    );

    uvs_emit u_emit (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(p_out_valid), .in_ready(e_in_ready), .in_res(p_res),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );
endmodule
`default_nettype wire

// ===== hw/rtl/uvs_front.sv =====
// Front end: count registers, input clamping and vertex index computation.
`timescale 1ns / 1ps
`default_nettype none
module uvs_front #(
    parameter int MAX_SLICES = uvs_pkg::MAX_SLICES_DEF,
    parameter int MAX_STACKS = uvs_pkg::MAX_STACKS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_quad,
    input  logic [uvs_pkg::CNT_W-1:0]      s_ring,
    input  logic [uvs_pkg::CNT_W-1:0]      s_col,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [uvs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [uvs_pkg::CNT_W-1:0]      cfg_data,
    input  logic                           q_full,
    output logic                           q_push,
    output uvs_pkg::item_t                 q_item,
    output logic [uvs_pkg::CNT_W-1:0]      sl,
    output logic [uvs_pkg::CNT_W-1:0]      st
);
    localparam logic [10:0] SL_HI = 11'(MAX_SLICES);
    localparam logic [10:0] ST_HI = 11'(MAX_STACKS);
    localparam logic [10:0] SL_LO = 11'd3;
    localparam logic [10:0] ST_LO = 11'd2;

    logic [uvs_pkg::CNT_W-1:0] slice_count_reg, stack_count_reg;
    logic [10:0] sl_w, st_w;
    logic [uvs_pkg::CNT_W-1:0] ring_lim, col_lim, ring_c, col_c;
    logic [9:0]  row;
    logic [18:0] prod;
    logic [uvs_pkg::IDX_W-1:0] idx0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slice_count_reg <= uvs_pkg::SLICE_RESET;
            stack_count_reg <= uvs_pkg::STACK_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                uvs_pkg::REG_SLICE_COUNT: slice_count_reg <= cfg_data;
                uvs_pkg::REG_STACK_COUNT: stack_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        sl_w = {2'b00, slice_count_reg};
        if (sl_w < SL_LO) sl_w = SL_LO;
        else if (sl_w > SL_HI) sl_w = SL_HI;
        st_w = {2'b00, stack_count_reg};
        if (st_w < ST_LO) st_w = ST_LO;
        else if (st_w > ST_HI) st_w = ST_HI;
    end

    assign sl = sl_w[uvs_pkg::CNT_W-1:0];
    assign st = st_w[uvs_pkg::CNT_W-1:0];

    // quads stop one short of the far edge
    assign ring_lim = s_quad ? st - 9'd1 : st;
    assign col_lim  = s_quad ? sl - 9'd1 : sl;
    assign ring_c   = (s_ring > ring_lim) ? ring_lim : s_ring;
    assign col_c    = (s_col > col_lim) ? col_lim : s_col;
    assign row      = {1'b0, sl} + 10'd1;
    assign prod     = ring_c * row;
    assign idx0     = 17'(prod + 19'(col_c));

    assign q_item.quad = s_quad;
    assign q_item.ring = ring_c;
    assign q_item.col  = col_c;
    assign q_item.idx0 = idx0;
    assign q_item.idx2 = 17'(idx0 + 17'(row));

    assign s_ready   = !q_full;
    assign q_push    = s_valid && !q_full;
    assign cfg_ready = 1'b1;
endmodule
`default_nettype wire

// ===== hw/rtl/uvs_fifo.sv =====
// Short item queue between the front end and the arithmetic pipeline.
`timescale 1ns / 1ps
`default_nettype none
module uvs_fifo #(
    parameter int DEPTH = uvs_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           full,
    input  uvs_pkg::item_t wr_item,
    output logic           rd_valid,
    input  logic           rd_ready,
    output uvs_pkg::item_t rd_item
);
    localparam int AW = $clog2(DEPTH);

    uvs_pkg::item_t mem_reg [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic wr, rd;

    assign full     = cnt_reg == (AW+1)'(DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_item  = mem_reg[rp_reg];
    assign wr       = wr_valid && !full;
    assign rd       = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (rd) rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            if (wr && !rd) cnt_reg <= cnt_reg + 1'b1;
            else if (rd && !wr) cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) mem_reg[wp_reg] <= wr_item;
    end
endmodule
`default_nettype wire

// ===== hw/rtl/uvs_sin.sv =====
// Pipelined fixed-point sine of a 20-bit phase, Q1.14 result.
`timescale 1ns / 1ps
`default_nettype none
module uvs_sin (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [uvs_pkg::PH_W-1:0]     phase,
    output logic signed [15:0]           sin_out
);
    logic [18:0] r_in;
    logic [18:0] r_reg [6];
    logic        neg_reg [7];
    logic [30:0] t2_reg [4];
    logic [30:0] p_reg [4];
    logic [31:0] s_reg;
    logic [37:0] sq;
    logic [61:0] hprod [4];
    logic [30:0] p_prev [4];
    logic [49:0] fprod;
    logic [15:0] s_rnd;
    logic [15:0] s_lim;

    // fold the quadrant onto the first quarter
    assign r_in = phase[18] ? 19'(uvs_pkg::QUARTER) - {1'b0, phase[17:0]}
                            : {1'b0, phase[17:0]};
    assign sq   = r_reg[0] * r_reg[0];

    always_comb begin
        for (int h = 0; h < 4; h++) begin
            p_prev[h] = (h == 0) ? uvs_pkg::SIN_A9 : p_reg[(h == 0) ? 0 : h-1];
            hprod[h]  = 62'(t2_reg[h]) * 62'(p_prev[h]);
        end
    end

    assign fprod = 50'(r_reg[5]) * 50'(p_reg[3]);
    assign s_rnd = 16'((s_reg + 32'd32768) >> 16);
    assign s_lim = (s_rnd > 16'd16384) ? 16'd16384 : s_rnd;

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]   <= r_in;
            neg_reg[0] <= phase[19];
            for (int k = 1; k < 6; k++) r_reg[k] <= r_reg[k-1];
            for (int k = 1; k < 7; k++) neg_reg[k] <= neg_reg[k-1];
            t2_reg[0] <= 31'(sq >> 6);
            for (int k = 1; k < 4; k++) t2_reg[k] <= t2_reg[k-1];
            for (int h = 0; h < 4; h++)
                p_reg[h] <= uvs_pkg::SIN_COEF[h] - 31'(hprod[h] >> 30);
            s_reg   <= 32'(fprod >> 18);
            sin_out <= neg_reg[6] ? -$signed(s_lim) : $signed(s_lim);
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/uvs_pipe.sv =====
// Back-end arithmetic: angle division, four sines and the normal products.
`timescale 1ns / 1ps
`default_nettype none
module uvs_pipe (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  uvs_pkg::item_t            in_item,
    input  logic [uvs_pkg::CNT_W-1:0] sl,
    input  logic [uvs_pkg::CNT_W-1:0] st,
    output logic                      out_valid,
    input  logic                      out_ready,
    output uvs_pkg::vtx_t             out_res
);
    localparam int NQ     = uvs_pkg::DIV_Q_W;
    localparam int NS     = uvs_pkg::SIN_LAT;
    localparam int PW     = uvs_pkg::PH_W;
    localparam int TEX_SH = NQ - 1 - 15;

    logic en;

    // divider: one quotient bit per stage, theta and phi side by side
    logic [NQ-1:0] dv_vld_reg;
    uvs_pkg::item_t dv_item_reg [NQ];
    logic [8:0]    rth_reg [NQ], rph_reg [NQ];
    logic [NQ-1:0] qth_reg [NQ], qph_reg [NQ];
    logic [9:0]    th_sh [NQ], ph_sh [NQ];
    logic          th_ge [NQ], ph_ge [NQ];

    // phase stage
    logic d_vld_reg;
    uvs_pkg::item_t d_item_reg;
    logic [14:0] d_tu_reg, d_tv_reg;
    logic [PW-1:0] ph_sp_reg, ph_cp_reg, ph_st_reg, ph_ct_reg;
    logic [NQ-1:0] qt_inc, qp_inc;
    logic [15:0]   tu_inc, tv_inc;

    // sine delay line
    logic [NS-1:0] s_vld_reg;
    uvs_pkg::item_t s_item_reg [NS];
    logic [14:0] s_tu_reg [NS], s_tv_reg [NS];
    logic signed [15:0] sn_phi, cs_phi, sn_th, cs_th;

    // product stage
    logic m_vld_reg;
    uvs_pkg::item_t m_item_reg;
    logic [14:0] m_tu_reg, m_tv_reg;
    logic signed [31:0] m_px_reg, m_pz_reg;
    logic signed [15:0] m_cp_reg, m_st_reg, m_ct_reg;

    logic out_valid_reg;
    uvs_pkg::vtx_t out_res_reg;

    function automatic logic signed [31:0] rnd_shift(input logic signed [31:0] v,
                                                      input int unsigned sh);
        logic [31:0] m;
        m = v[31] ? (~v + 32'd1) : v;
        m = (m + (32'd1 << (sh - 1))) >> sh;
        rnd_shift = v[31] ? -$signed(m) : $signed(m);
    endfunction

    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_comb begin
        th_sh[0] = '0;
        ph_sh[0] = '0;
        th_ge[0] = in_item.col >= sl;
        ph_ge[0] = in_item.ring >= st;
        for (int i = 1; i < NQ; i++) begin
            th_sh[i] = {rth_reg[i-1], 1'b0};
            ph_sh[i] = {rph_reg[i-1], 1'b0};
            th_ge[i] = th_sh[i] >= {1'b0, sl};
            ph_ge[i] = ph_sh[i] >= {1'b0, st};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_item_reg[0] <= in_item;
            rth_reg[0] <= th_ge[0] ? in_item.col - sl : in_item.col;
            rph_reg[0] <= ph_ge[0] ? in_item.ring - st : in_item.ring;
            qth_reg[0] <= {th_ge[0], {(NQ-1){1'b0}}};
            qph_reg[0] <= {ph_ge[0], {(NQ-1){1'b0}}};
            for (int i = 1; i < NQ; i++) begin
                dv_item_reg[i] <= dv_item_reg[i-1];
                rth_reg[i] <= th_ge[i] ? 9'(th_sh[i] - {1'b0, sl}) : th_sh[i][8:0];
                rph_reg[i] <= ph_ge[i] ? 9'(ph_sh[i] - {1'b0, st}) : ph_sh[i][8:0];
                qth_reg[i] <= qth_reg[i-1] | (NQ'(th_ge[i]) << (NQ-1-i));
                qph_reg[i] <= qph_reg[i-1] | (NQ'(ph_ge[i]) << (NQ-1-i));
            end
        end
    end

    // quotients are floor(x * 2^21 / d); round half up at each precision
    assign qt_inc = qth_reg[NQ-1] + 1'b1;
    assign qp_inc = {1'b0, qph_reg[NQ-1][NQ-1:1]} + 1'b1;
    assign tu_inc = 16'(qth_reg[NQ-1] >> TEX_SH) + 16'd1;
    assign tv_inc = 16'(qph_reg[NQ-1] >> TEX_SH) + 16'd1;

    always_ff @(posedge aclk) begin
        if (en) begin
            d_item_reg <= dv_item_reg[NQ-1];
            d_tu_reg   <= tu_inc[15:1];
            d_tv_reg   <= tv_inc[15:1];
            ph_sp_reg  <= qp_inc[PW:1];
            ph_cp_reg  <= qp_inc[PW:1] + uvs_pkg::QUARTER;
            ph_st_reg  <= qt_inc[PW:1];
            ph_ct_reg  <= qt_inc[PW:1] + uvs_pkg::QUARTER;
        end
    end

    uvs_sin u_sin_sp (.aclk(aclk), .en(en), .phase(ph_sp_reg), .sin_out(sn_phi));
    uvs_sin u_sin_cp (.aclk(aclk), .en(en), .phase(ph_cp_reg), .sin_out(cs_phi));
    uvs_sin u_sin_st (.aclk(aclk), .en(en), .phase(ph_st_reg), .sin_out(sn_th));
    uvs_sin u_sin_ct (.aclk(aclk), .en(en), .phase(ph_ct_reg), .sin_out(cs_th));

    always_ff @(posedge aclk) begin
        if (en) begin
            s_item_reg[0] <= d_item_reg;
            s_tu_reg[0]   <= d_tu_reg;
            s_tv_reg[0]   <= d_tv_reg;
            for (int i = 1; i < NS; i++) begin
                s_item_reg[i] <= s_item_reg[i-1];
                s_tu_reg[i]   <= s_tu_reg[i-1];
                s_tv_reg[i]   <= s_tv_reg[i-1];
            end
            m_item_reg <= s_item_reg[NS-1];
            m_tu_reg   <= s_tu_reg[NS-1];
            m_tv_reg   <= s_tv_reg[NS-1];
            m_px_reg   <= sn_phi * cs_th;
            m_pz_reg   <= sn_phi * sn_th;
            m_cp_reg   <= cs_phi;
            m_st_reg   <= sn_th;
            m_ct_reg   <= cs_th;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_res_reg.quad   <= m_item_reg.quad;
            out_res_reg.idx0   <= m_item_reg.idx0;
            out_res_reg.idx2   <= m_item_reg.idx2;
            out_res_reg.pos_x  <= 15'(rnd_shift(m_px_reg, 15));
            out_res_reg.pos_y  <= 15'(rnd_shift(32'(m_cp_reg), 1));
            out_res_reg.pos_z  <= 15'(rnd_shift(m_pz_reg, 15));
            out_res_reg.norm_x <= 16'(rnd_shift(m_px_reg, 14));
            out_res_reg.norm_y <= m_cp_reg;
            out_res_reg.norm_z <= 16'(rnd_shift(m_pz_reg, 14));
            out_res_reg.tex_u  <= m_tu_reg;
            out_res_reg.tex_v  <= m_tv_reg;
            out_res_reg.tan_x  <= -m_st_reg;
            out_res_reg.tan_z  <= m_ct_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_vld_reg    <= '0;
            d_vld_reg     <= 1'b0;
            s_vld_reg     <= '0;
            m_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            dv_vld_reg    <= {dv_vld_reg[NQ-2:0], in_valid};
            d_vld_reg     <= dv_vld_reg[NQ-1];
            s_vld_reg     <= {s_vld_reg[NS-2:0], d_vld_reg};
            m_vld_reg     <= s_vld_reg[NS-1];
            out_valid_reg <= m_vld_reg;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/uvs_emit.sv =====
// Result sequencer: one result per vertex item, six index results per quad item.
`timescale 1ns / 1ps
`default_nettype none
module uvs_emit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  uvs_pkg::vtx_t                   in_res,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [uvs_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tlast
);
    localparam logic [2:0] LAST_K = 3'd5;

    logic busy_reg;
    logic [2:0] k_reg;
    uvs_pkg::vtx_t res_reg;
    uvs_pkg::out_word_t w;
    logic last_now;
    logic [uvs_pkg::IDX_W-1:0] i1, i3;

    assign last_now = !res_reg.quad || (k_reg == LAST_K);
    assign in_ready = !busy_reg || (m_tready && last_now);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
        end else if (in_ready) begin
            busy_reg <= in_valid;
            k_reg    <= '0;
        end else if (m_tready) begin
            k_reg <= k_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) res_reg <= in_res;
    end

    assign i1 = res_reg.idx0 + 17'd1;
    assign i3 = res_reg.idx2 + 17'd1;

    always_comb begin
        w = '0;
        if (!res_reg.quad) begin
            w.pos_x        = res_reg.pos_x;
            w.pos_y        = res_reg.pos_y;
            w.pos_z        = res_reg.pos_z;
            w.norm_x       = res_reg.norm_x;
            w.norm_y       = res_reg.norm_y;
            w.norm_z       = res_reg.norm_z;
            w.tex_u        = res_reg.tex_u;
            w.tex_v        = res_reg.tex_v;
            w.tan_x        = res_reg.tan_x;
            w.tan_z        = res_reg.tan_z;
            w.vertex_index = res_reg.idx0;
        end else begin
            // corners i0 i1 i2 i2 i1 i3
            case (k_reg)
                3'd0:    w.vertex_index = res_reg.idx0;
                3'd1:    w.vertex_index = i1;
                3'd2:    w.vertex_index = res_reg.idx2;
                3'd3:    w.vertex_index = res_reg.idx2;
                3'd4:    w.vertex_index = i1;
                default: w.vertex_index = i3;
            endcase
        end
    end

    assign m_tvalid = busy_reg;
    assign m_tdata  = w;
    assign m_tlast  = last_now;
endmodule
`default_nettype wire

// ===== hw/rtl/uvs_checker.sv =====
// Port-level checks of the generator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module uvs_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [uvs_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                           m_tlast
);
    uvs_pkg::out_word_t w;
    assign w = m_tdata;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // only quad items give non-final results, and those carry the index alone
    a_quad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> w.pos_x == '0 && w.norm_x == '0 && w.norm_y == '0
            && w.tex_u == '0 && w.tex_v == '0 && w.tan_z == '0)
        else $error("quad result carries vertex fields");

    a_quad_cont: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("quad sequence broken off");

    a_tex_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> w.tex_u <= 15'd16384 && w.tex_v <= 15'd16384)
        else $error("texture coordinate above one");
endmodule

bind uv_sphere_vertex_index_gen uvs_checker u_uvs_checker (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tlast(m_tlast)
);
`default_nettype wire
